>>> sv/tts_pkg.sv
package tts_pkg;

	// token byte table; depth must be a power of two so the walk wraps by truncation
	localparam int TOKEN_TABLE_DEPTH = 4096;
	localparam int MAX_TOKEN_LEN     = 32;

	localparam int TT_AW       = $clog2(TOKEN_TABLE_DEPTH);
	localparam int OFFS_DEPTH  = 256;
	localparam int OFFS_AW     = $clog2(OFFS_DEPTH);
	localparam int OFF_W       = 12;
	localparam int TK_W        = $clog2(MAX_TOKEN_LEN + 1);

	localparam logic [1:0] KIND_OFFS   = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_STREAM = 2'd2;

	localparam logic [7:0] MAX_LEN_RST = 8'd128;

	typedef struct packed {
		logic [7:0] out_char;
		logic       is_terminator;
		logic       truncated;
		logic       last;
	} res_t;

endpackage

>>> sv/tts_item_if.sv
interface tts_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] address;
	logic [15:0] value;

	modport source (output valid, kind, address, value, input ready);
	modport sink (input valid, kind, address, value, output ready);
endinterface

>>> sv/tts_result_if.sv
interface tts_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_terminator;
	logic       truncated;
	logic       last;

	modport source (output valid, out_char, is_terminator, truncated, last, input ready);
	modport sink (input valid, out_char, is_terminator, truncated, last, output ready);
endinterface

>>> sv/tts_cfg_if.sv
interface tts_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] max_len;

	modport source (output valid, max_len, input ready);
	modport sink (input valid, max_len, output ready);
endinterface

>>> sv/tts_ram.sv
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tts_obuf.sv
module tts_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tts_pkg::res_t       din,
	output logic                rdy,
	tts_result_if.source        result
);

	logic          vld_q;
	tts_pkg::res_t data_q;

	// free when empty or when the held result leaves this cycle
	assign rdy = !vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push) begin
			vld_q <= 1'b1;
		end else if (result.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign result.valid         = vld_q;
	assign result.out_char      = data_q.out_char;
	assign result.is_terminator = data_q.is_terminator;
	assign result.truncated     = data_q.truncated;
	assign result.last          = data_q.last;

endmodule

>>> sv/token_table_symbol_expander.sv
// Channel  Dir  Payload                                   Transfer
// item     in   kind, address, value                      item.valid && item.ready
// result   out  out_char, is_terminator, truncated, last  result.valid && result.ready
// cfg      in   max_len                                   cfg.valid (ready tied high)
//
// Table writes, length prefixes and ignored items stay in idle; a zero prefix also flushes.
// A code byte of an uncut symbol passes through the transfer, the index RAM read,
// one byte RAM read per character, then the end check, the final step and the flush.
// Each result waits in a one-entry hold register until the next one shows whether it is
// the last of its item; a stalled result port freezes the walk by re-reading the same byte.
// arst_n clears the control state; both RAMs hold garbage until loaded.
module token_table_symbol_expander (
	input  logic          clk,
	input  logic          arst_n,
	tts_item_if.sink      item,
	tts_result_if.source  result,
	tts_cfg_if.sink       cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFS,
		ST_WALK,
		ST_FINAL,
		ST_FLUSH
	} state_t;

	state_t                        state_q;
	logic [7:0]                    codes_q;
	logic                          fs_q;
	logic [7:0]                    room_q;
	logic                          nd_q;
	logic [7:0]                    max_len_q;
	logic [tts_pkg::TT_AW-1:0]     pos_q;
	logic [tts_pkg::TK_W-1:0]      k_q;
	logic                          pend_vld_q;
	tts_pkg::res_t                 pend_q;

	logic                          item_xfer;
	logic [7:0]                    code_b;
	logic                          offs_we;
	logic                          tb_we;
	logic [tts_pkg::OFF_W-1:0]     offs_rdata;
	logic [7:0]                    tb_rdata;
	logic [tts_pkg::TT_AW-1:0]     tb_raddr;
	logic                          walk_stop;
	logic                          walk_adv;
	logic                          push_ok;
	logic                          res_load;
	tts_pkg::res_t                 res_new;
	logic                          ob_push;
	logic                          ob_rdy;
	tts_pkg::res_t                 ob_din;

	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer  = item.valid && item.ready;
	assign code_b     = item.value[7:0];
	assign cfg.ready  = 1'b1;

	// drop table writes that fall beyond either store
	assign offs_we = item_xfer && (item.kind == tts_pkg::KIND_OFFS)
		&& (32'(item.address) < tts_pkg::OFFS_DEPTH);
	assign tb_we   = item_xfer && (item.kind == tts_pkg::KIND_BYTE)
		&& (32'(item.address) < tts_pkg::TOKEN_TABLE_DEPTH);

	tts_ram #(
		.WIDTH (tts_pkg::OFF_W),
		.DEPTH (tts_pkg::OFFS_DEPTH)
	) u_offs_ram (
		.clk   (clk),
		.we    (offs_we),
		.waddr (item.address[tts_pkg::OFFS_AW-1:0]),
		.wdata (item.value[tts_pkg::OFF_W-1:0]),
		.raddr (code_b),
		.rdata (offs_rdata)
	);

	// the walk reads the byte at pos_q every cycle; advancing reads pos_q + 1 instead
	assign tb_raddr = (state_q == ST_OFFS) ? tts_pkg::TT_AW'(offs_rdata) :
		(walk_adv ? pos_q + 1'b1 : pos_q);

	tts_ram #(
		.WIDTH (8),
		.DEPTH (tts_pkg::TOKEN_TABLE_DEPTH)
	) u_tb_ram (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tts_pkg::TT_AW'(item.address)),
		.wdata (item.value[7:0]),
		.raddr (tb_raddr),
		.rdata (tb_rdata)
	);

	// a zero byte or a saturated length ends the token
	assign walk_stop = (tb_rdata == 8'd0) || (k_q == tts_pkg::TK_W'(tts_pkg::MAX_TOKEN_LEN));
	// a new result may replace the held one only if the output register takes the held one
	assign push_ok   = !pend_vld_q || ob_rdy;

	always_comb begin
		res_load = 1'b0;
		res_new  = '{out_char: 8'd0, is_terminator: 1'b1, truncated: 1'b0, last: 1'b0};
		walk_adv = 1'b0;
		ob_push  = 1'b0;
		ob_din   = pend_q;
		ob_din.last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// empty symbol: terminator at once unless the buffer has no room at all
				if (item_xfer && (item.kind == tts_pkg::KIND_STREAM) && (codes_q == 8'd0)
					&& (code_b == 8'd0) && (max_len_q != 8'd0)) begin
					res_load = 1'b1;
				end
			end
			ST_OFFS: begin
			end
			ST_WALK: begin
				if (!walk_stop) begin
					if (!fs_q) begin
						walk_adv = 1'b1;
					end else if (room_q > 8'd1) begin
						if (push_ok) begin
							res_load = 1'b1;
							res_new.out_char = tb_rdata;
							res_new.is_terminator = 1'b0;
							walk_adv = 1'b1;
						end
					end else if ((room_q != 8'd0) && push_ok) begin
						res_load = 1'b1;
						res_new.truncated = 1'b1;
					end
				end
			end
			ST_FINAL: begin
				if (!nd_q && (codes_q == 8'd0) && (room_q != 8'd0) && push_ok) begin
					res_load = 1'b1;
				end
			end
			ST_FLUSH: begin
				ob_push = pend_vld_q && ob_rdy;
				ob_din.last = 1'b1;
			end
			default: begin
			end
		endcase
		if (res_load && pend_vld_q) begin
			ob_push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			codes_q    <= 8'd0;
			fs_q       <= 1'b0;
			room_q     <= 8'd0;
			nd_q       <= 1'b0;
			max_len_q  <= tts_pkg::MAX_LEN_RST;
			pos_q      <= '0;
			k_q        <= '0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
		end else begin
			if (cfg.valid) begin
				max_len_q <= cfg.max_len;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer && (item.kind == tts_pkg::KIND_STREAM)) begin
						if (codes_q == 8'd0) begin
							// length prefix: open a new symbol
							codes_q <= code_b;
							fs_q    <= 1'b0;
							room_q  <= max_len_q;
							nd_q    <= (code_b == 8'd0);
							if (code_b == 8'd0) begin
								state_q <= ST_FLUSH;
							end
						end else begin
							codes_q <= codes_q - 8'd1;
							if (!nd_q) begin
								state_q <= ST_OFFS;
							end
						end
					end
				end
				ST_OFFS: begin
					pos_q   <= tts_pkg::TT_AW'(offs_rdata);
					k_q     <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_stop) begin
						state_q <= ST_FINAL;
					end else if (!fs_q) begin
						fs_q <= 1'b1;
					end else if (room_q > 8'd1) begin
						if (push_ok) begin
							room_q <= room_q - 8'd1;
						end
					end else if ((room_q == 8'd0) || push_ok) begin
						// out of room: cut the name, eat the remaining codes silently
						nd_q    <= 1'b1;
						state_q <= ST_FLUSH;
					end
					if (walk_adv) begin
						pos_q <= pos_q + 1'b1;
						k_q   <= k_q + 1'b1;
					end
				end
				ST_FINAL: begin
					if (!nd_q && (codes_q == 8'd0)) begin
						if ((room_q == 8'd0) || push_ok) begin
							nd_q    <= 1'b1;
							state_q <= ST_FLUSH;
						end
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q || ob_rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (res_load) begin
				pend_vld_q <= 1'b1;
				pend_q     <= res_new;
			end else if ((state_q == ST_FLUSH) && ob_push) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	tts_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ob_push),
		.din    (ob_din),
		.rdy    (ob_rdy),
		.result (result)
	);

	a_pend_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("held result left behind when returning to idle");

	a_push_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		ob_push |-> ob_rdy)
		else $error("result pushed into a full output register");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (k_q <= tts_pkg::TK_W'(tts_pkg::MAX_TOKEN_LEN)))
		else $error("token walk ran past its length limit");

	a_offs_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OFFS) |=> (state_q == ST_WALK))
		else $error("index read not followed by a token walk");

endmodule

>>> tb/token_table_symbol_expander_tb.sv
`timescale 1ns / 1ps

module token_table_symbol_expander_tb;

	// the item channel carries a fourth kind that the block must drop
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 9;
	// a code byte walks at most MAX_TOKEN_LEN bytes, plus its lookup and flush steps
	localparam int SETTLE_CYCLES    = 2 * tts_pkg::MAX_TOKEN_LEN + 16;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RANDOM_PHASE_ITEMS = 8;

	typedef logic [7:0] byte_list_t [$];

	logic clk = 1'b0;
	logic arst_n;

	tts_item_if   item_ch ();
	tts_result_if result_ch ();
	tts_cfg_if    cfg_ch ();

	token_table_symbol_expander uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow copy of the block: both tables with a loaded flag per entry, the
	// per-symbol walk state and the max_len register.
	logic [tts_pkg::OFF_W-1:0] offs_shadow [tts_pkg::OFFS_DEPTH];
	logic [7:0]       bytes_shadow [tts_pkg::TOKEN_TABLE_DEPTH];
	bit               offs_loaded [tts_pkg::OFFS_DEPTH];
	bit               byte_loaded [tts_pkg::TOKEN_TABLE_DEPTH];
	logic [7:0]       codes_left_s;
	logic [7:0]       room_left_s;
	logic [7:0]       max_len_s;
	bit               first_skipped_s;
	bit               name_done_s;

	// characters and terminators still owed by the block, oldest first
	tts_pkg::res_t expected_chars [$];

	int fail_count;
	int items_sent;
	int results_seen;
	int trunc_seen;
	int symbols_sent;

	bit tx_gaps;
	bit rx_gaps;
	bit hold_request;

	function automatic tts_pkg::res_t result_of(input logic [7:0] ch, input logic term,
			input logic trunc);
		tts_pkg::res_t r;
		r.out_char      = ch;
		r.is_terminator = term;
		r.truncated     = trunc;
		r.last          = 1'b0;
		return r;
	endfunction

	// Apply one accepted item to the shadow state and queue what it must produce.
	task automatic expand_item(input logic [1:0] kind, input logic [11:0] addr,
			input logic [15:0] value);
		tts_pkg::res_t    produced [$];
		logic [7:0]       b;
		logic [7:0]       ch;
		logic [tts_pkg::TT_AW-1:0] pos;
		b = value[7:0];
		case (kind)
			tts_pkg::KIND_OFFS: begin
				// entries past the index are dropped, not folded back
				if (addr < tts_pkg::OFFS_DEPTH) begin
					offs_shadow[addr[tts_pkg::OFFS_AW-1:0]] = value[tts_pkg::OFF_W-1:0];
					offs_loaded[addr[tts_pkg::OFFS_AW-1:0]] = 1'b1;
				end
			end
			tts_pkg::KIND_BYTE: begin
				if (addr < tts_pkg::TOKEN_TABLE_DEPTH) begin
					bytes_shadow[addr[tts_pkg::TT_AW-1:0]] = b;
					byte_loaded[addr[tts_pkg::TT_AW-1:0]]  = 1'b1;
				end
			end
			tts_pkg::KIND_STREAM: begin
				if (codes_left_s == 8'd0) begin
					// length prefix: open a new symbol and latch max_len now
					codes_left_s    = b;
					first_skipped_s = 1'b0;
					room_left_s     = max_len_s;
					name_done_s     = 1'b0;
					if (b == 8'd0) begin
						name_done_s = 1'b1;
						if (room_left_s != 8'd0)
							produced.push_back(result_of(8'h00, 1'b1, 1'b0));
					end
				end else begin
					codes_left_s--;
					// after truncation the remaining codes are swallowed
					if (!name_done_s) begin
						pos = tts_pkg::TT_AW'(offs_shadow[b]);
						for (int k = 0; k < tts_pkg::MAX_TOKEN_LEN; k++) begin
							ch = bytes_shadow[pos];
							if (ch == 8'h00)
								break;
							if (first_skipped_s) begin
								if (room_left_s <= 8'd1) begin
									name_done_s = 1'b1;
									if (room_left_s != 8'd0)
										produced.push_back(result_of(8'h00, 1'b1, 1'b1));
									break;
								end
								produced.push_back(result_of(ch, 1'b0, 1'b0));
								room_left_s--;
							end else begin
								// drop the type letter
								first_skipped_s = 1'b1;
							end
							pos++;
						end
						if (!name_done_s && codes_left_s == 8'd0) begin
							name_done_s = 1'b1;
							if (room_left_s != 8'd0)
								produced.push_back(result_of(8'h00, 1'b1, 1'b0));
						end
					end
				end
			end
			default: ;
		endcase
		if (produced.size() > 0)
			produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i])
			expected_chars.push_back(produced[i]);
	endtask

	// A code is safe to send only if its walk touches loaded entries alone.
	function automatic bit code_usable(input logic [7:0] code);
		logic [tts_pkg::TT_AW-1:0] pos;
		if (!offs_loaded[code])
			return 1'b0;
		pos = tts_pkg::TT_AW'(offs_shadow[code]);
		for (int k = 0; k < tts_pkg::MAX_TOKEN_LEN; k++) begin
			if (!byte_loaded[pos])
				return 1'b0;
			if (bytes_shadow[pos] == 8'h00)
				return 1'b1;
			pos++;
		end
		return 1'b1;
	endfunction

	// Offer one item, hold it until the transfer, then maybe idle for a burst.
	task automatic send_item(input logic [1:0] kind, input logic [11:0] addr,
			input logic [15:0] value);
		item_ch.valid   <= 1'b1;
		item_ch.kind    <= kind;
		item_ch.address <= addr;
		item_ch.value   <= value;
		do @(posedge clk); while (!item_ch.ready);
		expand_item(kind, addr, value);
		items_sent++;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Write the token bytes with a zero after them, then point the code at them.
	task automatic load_token(input logic [7:0] code, input logic [11:0] offset,
			input byte_list_t chars);
		logic [11:0] a;
		a = offset;
		foreach (chars[i]) begin
			send_item(tts_pkg::KIND_BYTE, a, {8'($urandom), chars[i]});
			a++;
		end
		send_item(tts_pkg::KIND_BYTE, a, {8'($urandom), 8'h00});
		send_item(tts_pkg::KIND_OFFS, {4'h0, code}, {4'($urandom), offset});
	endtask

	task automatic load_random_token();
		byte_list_t  chars;
		int          len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(tts_pkg::MAX_TOKEN_LEN + 1, 40)
			: $urandom_range(1, 6);
		repeat (len) chars.push_back(8'($urandom_range(1, 255)));
		load_token(8'($urandom), 12'($urandom), chars);
	endtask

	// Choose a random code among the safe ones; rebuild one if none is left.
	task automatic pick_code(output logic [7:0] code);
		byte_list_t safe;
		for (int c = 0; c < tts_pkg::OFFS_DEPTH; c++)
			if (code_usable(8'(c)))
				safe.push_back(8'(c));
		if (safe.size() == 0) begin
			load_token(8'h00, 12'h010, '{8'h61, 8'h62});
			safe.push_back(8'h00);
		end
		code = safe[$urandom_range(0, safe.size() - 1)];
	endtask

	// Items that leave the stream state alone: unused kind, stray writes, new tokens.
	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_item(KIND_UNUSED, 12'($urandom), 16'($urandom));
			1: send_item(tts_pkg::KIND_OFFS, 12'($urandom_range(tts_pkg::OFFS_DEPTH, 4095)),
				16'($urandom));
			2: send_item(tts_pkg::KIND_BYTE, 12'($urandom), 16'($urandom));
			default: load_random_token();
		endcase
	endtask

	task automatic send_codes(input byte_list_t codes);
		send_item(tts_pkg::KIND_STREAM, 12'($urandom), {8'($urandom), 8'(codes.size())});
		symbols_sent++;
		foreach (codes[i])
			send_item(tts_pkg::KIND_STREAM, 12'($urandom), {8'($urandom), codes[i]});
	endtask

	// A symbol of random safe codes; table traffic may cut in between codes.
	task automatic send_symbol(input int n_codes, input bit with_noise);
		logic [7:0] code;
		send_item(tts_pkg::KIND_STREAM, 12'($urandom), {8'($urandom), 8'(n_codes)});
		symbols_sent++;
		for (int i = 0; i < n_codes; i++) begin
			if (with_noise && $urandom_range(0, 7) == 0)
				send_noise();
			pick_code(code);
			send_item(tts_pkg::KIND_STREAM, 12'($urandom), {8'($urandom), code});
		end
	endtask

	// Drop valid, wait until every owed result is in, then let a silent walk finish.
	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [7:0] v);
		wait_for_drain();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.max_len <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		max_len_s = v;
	endtask

	// Tokens used by the directed tests:
	//   0x00 "ab", 0xFF a lone 0xFF, 0x01 empty, 0x02 wraps past the table end,
	//   0x03 longer than MAX_TOKEN_LEN, 0x04 points into the middle of 0x03.
	task automatic test_table_load();
		byte_list_t long_chars;
		for (int i = 0; i < 40; i++)
			long_chars.push_back((i == 20) ? 8'h80 : 8'(8'h41 + i % 26));
		load_token(8'h00, 12'h010, '{8'h61, 8'h62});
		load_token(8'hFF, 12'h020, '{8'hFF});
		load_token(8'h01, 12'h030, '{});
		load_token(8'h02, 12'hFFD, '{8'h70, 8'h71, 8'h72, 8'h01});
		load_token(8'h03, 12'h100, long_chars);
		send_item(tts_pkg::KIND_OFFS, 12'h004, 16'hF104);
	endtask

	task automatic test_plain_symbols();
		send_codes('{8'h00, 8'hFF, 8'h02});
		send_symbol(0, 1'b0);
		// an empty first token must not eat the type letter
		send_codes('{8'h01, 8'h00});
		send_codes('{8'h04});
		send_codes('{8'h03});
	endtask

	task automatic test_ignored_items();
		send_item(KIND_UNUSED, 12'hFFF, 16'hFFFF);
		send_item(KIND_UNUSED, 12'h000, 16'h0002);
		// index writes past 255 must not alias onto low codes
		send_item(tts_pkg::KIND_OFFS, 12'h100, 16'h0030);
		send_item(tts_pkg::KIND_OFFS, 12'hFFF, 16'h0030);
		send_codes('{8'h00});
	endtask

	task automatic test_truncation();
		set_max_len(8'd4);
		send_codes('{8'h03, 8'h00, 8'hFF});
		set_max_len(8'd1);
		send_codes('{8'h00, 8'h00});
		set_max_len(8'd2);
		send_codes('{8'h00});
		send_codes('{8'hFF, 8'hFF});
		set_max_len(8'd0);
		send_symbol(0, 1'b0);
		send_codes('{8'h03, 8'h00});
		set_max_len(8'd255);
		send_codes('{8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03});
		set_max_len(tts_pkg::MAX_LEN_RST);
	endtask

	// Stall the result side for a long stretch while long walks keep coming.
	task automatic test_backpressure();
		wait_for_drain();
		hold_request = 1'b1;
		tx_gaps      = 1'b0;
		send_codes('{8'h03, 8'h03});
		send_codes('{8'h04, 8'h02, 8'h00});
		send_codes('{8'h03, 8'hFF});
		tx_gaps = 1'b1;
		wait_for_drain();
	endtask

	task automatic test_random();
		logic [7:0] phase_len [4];
		int         start;
		int         pick;
		phase_len[0] = 8'($urandom_range(2, 10));
		phase_len[1] = 8'd255;
		phase_len[2] = 8'($urandom);
		phase_len[3] = 8'($urandom_range(11, 40));
		foreach (phase_len[p]) begin
			set_max_len(phase_len[p]);
			start = items_sent;
			while (items_sent - start < RANDOM_PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					if ($urandom_range(0, 9) == 0)
						send_symbol(0, 1'b1);
					else if ($urandom_range(0, 9) == 0)
						send_symbol($urandom_range(7, 12), 1'b1);
					else
						send_symbol($urandom_range(1, 6), 1'b1);
				end else begin
					send_noise();
				end
			end
		end
	endtask

	// Closing stretch: clean symbols with both sides running flat out.
	task automatic test_streaming();
		int start;
		set_max_len(8'($urandom_range(16, 64)));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		start = items_sent;
		while (items_sent - start < 14)
			send_symbol($urandom_range(1, 5), 1'b0);
	endtask

	// Result side: ready bursts, random stalls, and the long hold on request.
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare every result transfer against the oldest owed result.
	always @(posedge clk) begin
		tts_pkg::res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (result_ch.truncated)
				trunc_seen++;
			if (expected_chars.size() == 0) begin
				$error("result transfer with nothing owed: out_char %0h term %0b last %0b",
					result_ch.out_char, result_ch.is_terminator, result_ch.last);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				check_field("out_char", want.out_char, result_ch.out_char);
				check_field("is_terminator", 8'(want.is_terminator), 8'(result_ch.is_terminator));
				check_field("truncated", 8'(want.truncated), 8'(result_ch.truncated));
				check_field("last", 8'(want.last), 8'(result_ch.last));
			end
		end
	end

	// Hard stop: well past the slowest legal run, long holds and full stalls included.
	initial begin
		#(12_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.kind    = tts_pkg::KIND_OFFS;
		item_ch.address = 12'h000;
		item_ch.value   = 16'h0000;
		cfg_ch.valid    = 1'b0;
		cfg_ch.max_len  = 8'h00;
		codes_left_s    = 8'd0;
		room_left_s     = 8'd0;
		first_skipped_s = 1'b0;
		name_done_s     = 1'b0;
		max_len_s       = tts_pkg::MAX_LEN_RST;
		tx_gaps         = 1'b1;
		rx_gaps         = 1'b1;
		hold_request    = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_plain_symbols();
		test_ignored_items();
		test_truncation();
		test_backpressure();
		test_random();
		test_streaming();

		wait_for_drain();
		$display("Sent %0d input transfers in %0d symbols; checked %0d results, %0d cut short.",
			items_sent, symbols_sent, results_seen, trunc_seen);
		$display("Covered wrapped, empty and over-long tokens, ignored items, max_len 0 to 255.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> token_table_symbol_expander.f
sv/tts_pkg.sv
sv/tts_item_if.sv
sv/tts_result_if.sv
sv/tts_cfg_if.sv
sv/tts_ram.sv
sv/tts_obuf.sv
sv/token_table_symbol_expander.sv
tb/token_table_symbol_expander_tb.sv
